@@ hdl/lfsa_pkg.sv @@
// Package for the lowest-free server allocator: sizes, types and sequencer states.
`default_nettype none

package lfsa_pkg;

  localparam int unsigned SERVERS = 128;
  localparam int unsigned IDX_W   = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int unsigned CNT_W   = $clog2(SERVERS + 1);

  localparam int unsigned START_W = 32;
  localparam int unsigned WANT_W  = 8;
  localparam int unsigned HOLD_W  = 16;
  localparam int unsigned BUSY_W  = 33;
  localparam int unsigned SUM_W   = 14;
  localparam int unsigned ACT_W   = 8;

  // common width for comparing counts against 8-bit fields
  localparam int unsigned CMP_W   = (CNT_W > ACT_W) ? CNT_W : ACT_W;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(128);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_ALLOC,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic [START_W-1:0] start_time;
    logic [WANT_W-1:0]  servers_wanted;
    logic [HOLD_W-1:0]  hold_time;
  } req_t;

  typedef struct packed {
    logic             granted;
    logic [SUM_W-1:0] id_sum;
  } res_t;

  typedef struct packed {
    logic              ren;
    logic [IDX_W-1:0]  raddr;
    logic              wen;
    logic [IDX_W-1:0]  waddr;
    logic [BUSY_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic [BUSY_W-1:0] data;
    logic              written;
  } ram_rsp_t;

endpackage

`default_nettype wire

@@ hdl/lfsa_busy_ram.sv @@
// Busy-until store: one read and one write port, per-entry written flags.
`default_nettype none

module lfsa_busy_ram (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  lfsa_pkg::ram_req_t   req_i,
  output lfsa_pkg::ram_rsp_t   rsp_o
);

  logic [lfsa_pkg::BUSY_W-1:0]  mem [lfsa_pkg::SERVERS];
  logic [lfsa_pkg::SERVERS-1:0] vld_q;
  logic [lfsa_pkg::BUSY_W-1:0]  rdata_q;
  logic                         written_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wen) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.ren) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  // unwritten entries report the written flag low (server free)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      written_q <= 1'b0;
    end else begin
      if (req_i.wen) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.ren) begin
        written_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rsp_o.data    = rdata_q;
  assign rsp_o.written = written_q;

endmodule

`default_nettype wire

@@ hdl/lfsa_seq.sv @@
// Sequencer: count pass, then an allocation pass when granted, over the busy-until store.
`default_nettype none

module lfsa_seq (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          req_valid_i,
  output logic                         req_ready_o,
  input  lfsa_pkg::req_t               req_i,
  input  wire [lfsa_pkg::CNT_W-1:0]    usable_i,
  output lfsa_pkg::ram_req_t           ram_req_o,
  input  lfsa_pkg::ram_rsp_t           ram_rsp_i,
  output logic                         res_valid_o,
  input  wire                          res_ready_i,
  output lfsa_pkg::res_t               res_o
);

  lfsa_pkg::seq_state_e state_q, state_d;

  logic [lfsa_pkg::START_W-1:0] start_q;
  logic [lfsa_pkg::WANT_W-1:0]  wanted_q;
  logic [lfsa_pkg::BUSY_W-1:0]  busy_val_q;
  logic [lfsa_pkg::CNT_W-1:0]   n_q;
  logic [lfsa_pkg::CNT_W-1:0]   idx_q;
  logic [lfsa_pkg::IDX_W-1:0]   cmp_idx_q;
  logic                         cmp_vld_q;
  logic [lfsa_pkg::CNT_W-1:0]   found_q;
  logic [lfsa_pkg::SUM_W-1:0]   sum_q;
  logic [lfsa_pkg::SERVERS-1:0] take_q;
  logic                         grant_q;

  logic                       rd_more;
  logic                       alloc_more;
  logic [lfsa_pkg::CNT_W-1:0] alloc_idx;
  logic                       need;
  logic                       free;
  logic                       pass_end;

  assign rd_more    = (idx_q != n_q);
  assign alloc_more = (idx_q != '0);
  assign alloc_idx  = idx_q - lfsa_pkg::CNT_W'(1);
  assign need       = (lfsa_pkg::CMP_W'(found_q) < lfsa_pkg::CMP_W'(wanted_q));
  assign free       = !ram_rsp_i.written || (ram_rsp_i.data <= {1'b0, start_q});
  assign pass_end   = !rd_more && !cmp_vld_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lfsa_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          state_d = lfsa_pkg::ST_COUNT;
        end
      end
      lfsa_pkg::ST_COUNT: begin
        if (pass_end) begin
          state_d = need ? lfsa_pkg::ST_DONE : lfsa_pkg::ST_ALLOC;
        end
      end
      lfsa_pkg::ST_ALLOC: begin
        if (!alloc_more) begin
          state_d = lfsa_pkg::ST_DONE;
        end
      end
      lfsa_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = lfsa_pkg::ST_IDLE;
        end
      end
      default: state_d = lfsa_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready_o     = (state_q == lfsa_pkg::ST_IDLE);
    res_valid_o     = (state_q == lfsa_pkg::ST_DONE);
    res_o.granted   = grant_q;
    res_o.id_sum    = grant_q ? sum_q : '0;
    ram_req_o.ren   = (state_q == lfsa_pkg::ST_COUNT) && rd_more;
    ram_req_o.raddr = idx_q[lfsa_pkg::IDX_W-1:0];
    ram_req_o.wen   = (state_q == lfsa_pkg::ST_ALLOC) && alloc_more && take_q[0];
    ram_req_o.waddr = alloc_idx[lfsa_pkg::IDX_W-1:0];
    ram_req_o.wdata = busy_val_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lfsa_pkg::ST_IDLE;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == lfsa_pkg::ST_COUNT) && rd_more;
    end
  end

  // take flags shift in as entries are compared (lowest first); the allocation
  // pass walks the entries downward and shifts the flags back out at bit 0
  always_ff @(posedge clk_i) begin
    case (state_q)
      lfsa_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          start_q    <= req_i.start_time;
          wanted_q   <= req_i.servers_wanted;
          busy_val_q <= lfsa_pkg::BUSY_W'(req_i.start_time)
                        + lfsa_pkg::BUSY_W'(req_i.hold_time);
          n_q        <= usable_i;
          idx_q      <= '0;
          found_q    <= '0;
          sum_q      <= '0;
          take_q     <= '0;
        end
      end
      lfsa_pkg::ST_COUNT: begin
        if (rd_more) begin
          idx_q <= idx_q + lfsa_pkg::CNT_W'(1);
        end
        cmp_idx_q <= idx_q[lfsa_pkg::IDX_W-1:0];
        if (cmp_vld_q) begin
          take_q <= (take_q << 1) | lfsa_pkg::SERVERS'(free && need);
        end
        if (cmp_vld_q && free && need) begin
          found_q <= found_q + lfsa_pkg::CNT_W'(1);
          sum_q   <= sum_q + lfsa_pkg::SUM_W'(cmp_idx_q) + lfsa_pkg::SUM_W'(1);
        end
        if (pass_end) begin
          idx_q   <= n_q;
          grant_q <= !need;
        end
      end
      lfsa_pkg::ST_ALLOC: begin
        if (alloc_more) begin
          idx_q  <= alloc_idx;
          take_q <= take_q >> 1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/lowest_free_server_allocator.sv @@
// Top level of the lowest-free server allocator.
`default_nettype none

//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_wdata_i     | in
//  in      | in_valid_i, in_ready_o, start_time_i,     | in
//          | servers_wanted_i, hold_time_i             |
//  out     | out_valid_o, out_ready_i, granted_o,      | out
//          | id_sum_o                                  |
//
// A granted request goes through a count pass over N = min(active_servers, SERVERS) entries,
// which reads one entry a cycle, and then an allocation pass that writes the taken entries.
// A refused request skips the allocation pass.
// Reset clears the store's written flags, so every server starts free; no clearing pass.
// in_ready_o is low during the passes; the result moves into an output register, so one
// stalled result does not hold off the next request.

module lowest_free_server_allocator (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [lfsa_pkg::ACT_W-1:0]    cfg_wdata_i,
  // request
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire [lfsa_pkg::START_W-1:0]  start_time_i,
  input  wire [lfsa_pkg::WANT_W-1:0]   servers_wanted_i,
  input  wire [lfsa_pkg::HOLD_W-1:0]   hold_time_i,
  // result
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic                         granted_o,
  output logic [lfsa_pkg::SUM_W-1:0]   id_sum_o
);

  logic [lfsa_pkg::ACT_W-1:0] active_q;
  logic [lfsa_pkg::CNT_W-1:0] usable;
  logic [lfsa_pkg::CMP_W-1:0] act_ext;

  lfsa_pkg::req_t     req;
  lfsa_pkg::res_t     res;
  lfsa_pkg::ram_req_t ram_req;
  lfsa_pkg::ram_rsp_t ram_rsp;
  logic               res_valid;
  logic               res_ready;

  logic                       out_valid_q;
  logic                       granted_q;
  logic [lfsa_pkg::SUM_W-1:0] id_sum_q;

  // config register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= lfsa_pkg::ACTIVE_RESET;
    end else if (cfg_valid_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // active count saturates at the store depth
  assign act_ext = lfsa_pkg::CMP_W'(active_q);
  assign usable  = (act_ext > lfsa_pkg::CMP_W'(lfsa_pkg::SERVERS))
                   ? lfsa_pkg::CNT_W'(lfsa_pkg::SERVERS)
                   : lfsa_pkg::CNT_W'(active_q);

  assign req.start_time     = start_time_i;
  assign req.servers_wanted = servers_wanted_i;
  assign req.hold_time      = hold_time_i;

  lfsa_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (req),
    .usable_i    (usable),
    .ram_req_o   (ram_req),
    .ram_rsp_i   (ram_rsp),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  lfsa_busy_ram u_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ram_req),
    .rsp_o  (ram_rsp)
  );

  // output register: takes a result when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      granted_q <= res.granted;
      id_sum_q  <= res.id_sum;
    end
  end

  assign out_valid_o = out_valid_q;
  assign granted_o   = granted_q;
  assign id_sum_o    = id_sum_q;

  // the input side is closed in the cycle after a request is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted again right after a transaction");

  // a refusal never reports servers
  a_refuse_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !granted_o) |-> (id_sum_o == '0))
    else $error("refused transaction with nonzero id_sum");

  // a new result is loaded only from a request in progress
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while sequencer idle");

endmodule

`default_nettype wire
